>>> src/esc_pkg.sv
// shared types, constants and calendar helpers for the epoch seconds calendar converter
package esc_pkg;

  localparam int IN_TDATA_W  = 72;
  localparam int OUT_TDATA_W = 72;

  // serial divider widths: 16-bit dividend, 17-bit partial remainder and divisor
  localparam int DVD_W = 16;
  localparam int REM_W = 17;
  localparam int CNT_W = 5;
  localparam int YOFF_W = 8;

  localparam logic [REM_W-1:0] SECS_PER_DAY  = 17'd86400;
  localparam logic [REM_W-1:0] SECS_PER_HOUR = 17'd3600;
  localparam logic [REM_W-1:0] SECS_PER_MIN  = 17'd60;
  localparam logic [REM_W-1:0] DAYS_PER_YEAR = 17'd365;

  localparam logic [CNT_W-1:0] DAY_STEPS  = 5'd16;
  localparam logic [CNT_W-1:0] YEAR_STEPS = 5'd8;
  localparam logic [CNT_W-1:0] HOUR_STEPS = 5'd5;
  localparam logic [CNT_W-1:0] MIN_STEPS  = 5'd6;

  localparam logic [11:0] BASE_YEAR = 12'd1970;
  localparam logic [11:0] LAST_YEAR = 12'd2099;
  localparam logic [YOFF_W-1:0] YEAR_SPAN = 8'd129;
  localparam logic [31:0] LAST_SECOND = 32'd4102444799;

  localparam logic [3:0] LAST_MONTH_IDX = 4'd11;

  typedef struct packed {
    logic             load;
    logic [REM_W-1:0] rem;
    logic [DVD_W-1:0] dvd;
    logic [REM_W-1:0] divisor;
    logic [CNT_W-1:0] steps;
  } sdiv_req_t;

  typedef struct packed {
    logic             busy;
    logic [DVD_W-1:0] quo;
    logic [REM_W-1:0] rem;
  } sdiv_rsp_t;

  // year offset from 1970 is a leap year when the calendar year is a multiple of four
  function automatic logic is_leap(input logic [YOFF_W-1:0] yoff);
    is_leap = (yoff[1:0] == 2'd2);
  endfunction

  // month index counted from 0
  function automatic logic [4:0] month_len(input logic [3:0] m, input logic leap);
    logic [4:0] len;
    case (m)
      4'd1: len = leap ? 5'd29 : 5'd28;
      4'd3, 4'd5, 4'd8, 4'd10: len = 5'd30;
      default: len = 5'd31;
    endcase
    month_len = len;
  endfunction

  function automatic logic [8:0] days_before_month(input logic [3:0] m, input logic leap);
    logic [8:0] d;
    case (m)
      4'd0: d = 9'd0;
      4'd1: d = 9'd31;
      4'd2: d = 9'd59;
      4'd3: d = 9'd90;
      4'd4: d = 9'd120;
      4'd5: d = 9'd151;
      4'd6: d = 9'd181;
      4'd7: d = 9'd212;
      4'd8: d = 9'd243;
      4'd9: d = 9'd273;
      4'd10: d = 9'd304;
      default: d = 9'd334;
    endcase
    if (leap && m >= 4'd2) begin
      d = d + 9'd1;
    end
    days_before_month = d;
  endfunction

endpackage

>>> src/esc_sdiv.sv
// restoring shift-subtract divider, one quotient bit per cycle
module esc_sdiv (
  input  logic                 clk,
  input  logic                 rst_n,
  input  esc_pkg::sdiv_req_t   req_i,
  output esc_pkg::sdiv_rsp_t   rsp_o
);

  localparam int DW = esc_pkg::DVD_W;
  localparam int RW = esc_pkg::REM_W;
  localparam int CW = esc_pkg::CNT_W;

  logic [RW-1:0] p_r, p_nxt;
  logic [DW-1:0] d_r, d_nxt;
  logic [RW-1:0] dv_r, dv_nxt;
  logic [CW-1:0] cnt_r, cnt_nxt;
  logic [RW:0]   trial;
  logic [RW:0]   diff;

  always_comb begin
    trial   = {p_r, d_r[DW-1]};
    diff    = trial - {1'b0, dv_r};
    p_nxt   = p_r;
    d_nxt   = d_r;
    dv_nxt  = dv_r;
    cnt_nxt = cnt_r;
    if (req_i.load) begin
      p_nxt   = req_i.rem;
      d_nxt   = req_i.dvd;
      dv_nxt  = req_i.divisor;
      cnt_nxt = req_i.steps;
    end else if (cnt_r != '0) begin
      // top bit of diff set means the trial subtract borrowed
      if (!diff[RW]) begin
        p_nxt = diff[RW-1:0];
        d_nxt = {d_r[DW-2:0], 1'b1};
      end else begin
        p_nxt = trial[RW-1:0];
        d_nxt = {d_r[DW-2:0], 1'b0};
      end
      cnt_nxt = cnt_r - CW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
    end else begin
      cnt_r <= cnt_nxt;
    end
    p_r  <= p_nxt;
    d_r  <= d_nxt;
    dv_r <= dv_nxt;
  end

  assign rsp_o.busy = (cnt_r != '0);
  assign rsp_o.quo  = d_r;
  assign rsp_o.rem  = p_r;

endmodule

>>> src/epoch_seconds_calendar_converter.sv
// top level of the epoch seconds to calendar date and time converter
//
// One request on the in_ channel gives one result on the out_ channel.
// in_tuser selects the direction: 0 turns calendar fields into seconds
// since 1970-01-01 00:00:00, 1 turns seconds into calendar fields.
// Work from acceptance to out_tvalid; the next request can be taken in the cycle in which out_tvalid rises:
//   calendar to seconds: a short chain of shift-add steps
//   seconds to calendar: a serial divider splits the
//   seconds into days and time of day at one quotient bit per cycle,
//   then divides the days by 365 while a second
//   divider splits the time of day, and the month is found by a walk of
//   one month per cycle
//   seconds past 2099-12-31 23:59:59: fields saturate and
//   out_tuser flags the overflow
// One request is worked on at a time; in_tready is high while the block
// waits for a request, also while a finished result sits unclaimed in
// the output register. A stalled receiver holds the result; a further
// finished result waits inside until the output register is free.
// Reset empties the output register and returns to waiting.
module epoch_seconds_calendar_converter (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  // epoch_seconds[31:0], in_year[43:32], in_month[47:44], in_day[52:48],
  // in_hour[57:53], in_minute[63:58], in_second[69:64], zero fill
  input  logic [71:0] in_tdata,
  // req_type
  input  logic [0:0]  in_tuser,
  output logic        out_tvalid,
  input  logic        out_tready,
  // out_seconds[31:0], out_year[43:32], out_month[47:44], out_day[52:48],
  // out_hour[57:53], out_minute[63:58], out_second[69:64], zero fill
  output logic [71:0] out_tdata,
  // out_of_range
  output logic [0:0]  out_tuser
);

  localparam int YW = esc_pkg::YOFF_W;

  typedef enum logic [3:0] {
    S_IDLE, S_DAYS, S_YEAR, S_MONTH, S_CBASE, S_CDAYS, S_CHOUR, S_CMIN, S_CSEC, S_DONE
  } state_t;

  typedef enum logic [1:0] {B_IDLE, B_HOUR, B_MIN, B_FIN} b_stage_t;

  state_t   state_r, state_nxt;
  b_stage_t b_stage_r, b_stage_nxt;

  logic        mode_r, mode_nxt;
  logic [11:0] year_in_r, year_in_nxt;
  logic [3:0]  month_in_r, month_in_nxt;
  logic [4:0]  day_in_r, day_in_nxt;
  logic [4:0]  hour_r, hour_nxt;
  logic [5:0]  min_r, min_nxt;
  logic [5:0]  sec_r, sec_nxt;
  logic [31:0] acc_r, acc_nxt;
  logic [YW-1:0] yr_r, yr_nxt;
  logic [3:0]  mon_r, mon_nxt;
  logic [8:0]  diy_r, diy_nxt;
  logic        oor_r, oor_nxt;

  logic [71:0] out_tdata_r, out_tdata_nxt;
  logic        out_tuser_r, out_tuser_nxt;
  logic        out_tvalid_r, out_tvalid_nxt;

  esc_pkg::sdiv_req_t a_req, b_req;
  esc_pkg::sdiv_rsp_t a_rsp, b_rsp;

  logic        accept;
  logic [31:0] ts_in;

  // calendar to seconds helpers
  logic [YW-1:0] ycl;
  logic [3:0]    mi;
  logic [4:0]    dd;
  logic [16:0]   base_days;
  logic [8:0]    dbm;

  // year correction helpers
  logic [YW-1:0] q_est;
  logic [8:0]    r_est;
  logic [8:0]    leap_days;
  logic [9:0]    back_diy;
  logic [4:0]    mlen;

  logic [11:0] res_year;
  logic [3:0]  res_month;
  logic [4:0]  res_day;
  logic        res_oor;

  esc_sdiv u_div_a (
    .clk   (clk),
    .rst_n (rst_n),
    .req_i (a_req),
    .rsp_o (a_rsp)
  );

  esc_sdiv u_div_b (
    .clk   (clk),
    .rst_n (rst_n),
    .req_i (b_req),
    .rsp_o (b_rsp)
  );

  assign in_tready = (state_r == S_IDLE);
  assign accept    = in_tvalid && in_tready;
  assign ts_in     = in_tdata[31:0];

  always_comb begin
    if (year_in_r < esc_pkg::BASE_YEAR) begin
      ycl = '0;
    end else if (year_in_r > esc_pkg::LAST_YEAR) begin
      ycl = esc_pkg::YEAR_SPAN;
    end else begin
      ycl = YW'(year_in_r - esc_pkg::BASE_YEAR);
    end
    if (month_in_r == 4'd0) begin
      mi = 4'd0;
    end else if (month_in_r > 4'd12) begin
      mi = esc_pkg::LAST_MONTH_IDX;
    end else begin
      mi = month_in_r - 4'd1;
    end
    dd        = (day_in_r == 5'd0) ? 5'd0 : day_in_r - 5'd1;
    base_days = 17'(ycl) * esc_pkg::DAYS_PER_YEAR + 17'((9'(ycl) + 9'd1) >> 2);
    dbm       = esc_pkg::days_before_month(mi, esc_pkg::is_leap(ycl));
  end

  always_comb begin
    q_est     = a_rsp.quo[YW-1:0];
    r_est     = a_rsp.rem[8:0];
    leap_days = (9'(q_est) + 9'd1) >> 2;
    // estimate one year too high: fall back into the previous year
    back_diy  = 10'(r_est) + 10'(esc_pkg::DAYS_PER_YEAR) - 10'(q_est >> 2);
    mlen      = esc_pkg::month_len(mon_r, esc_pkg::is_leap(yr_r));
  end

  always_comb begin
    res_year  = 12'(yr_r) + esc_pkg::BASE_YEAR;
    res_month = mon_r + 4'd1;
    res_day   = diy_r[4:0] + 5'd1;
    res_oor   = mode_r ? oor_r : (acc_r > esc_pkg::LAST_SECOND);
  end

  always_comb begin
    state_nxt      = state_r;
    b_stage_nxt    = b_stage_r;
    mode_nxt       = mode_r;
    year_in_nxt    = year_in_r;
    month_in_nxt   = month_in_r;
    day_in_nxt     = day_in_r;
    hour_nxt       = hour_r;
    min_nxt        = min_r;
    sec_nxt        = sec_r;
    acc_nxt        = acc_r;
    yr_nxt         = yr_r;
    mon_nxt        = mon_r;
    diy_nxt        = diy_r;
    oor_nxt        = oor_r;
    out_tdata_nxt  = out_tdata_r;
    out_tuser_nxt  = out_tuser_r;
    out_tvalid_nxt = out_tvalid_r && !out_tready;
    a_req          = '0;
    b_req          = '0;

    // time of day split runs beside the year and month search
    case (b_stage_r)
      B_HOUR: begin
        if (!b_rsp.busy) begin
          hour_nxt      = b_rsp.quo[4:0];
          b_req.load    = 1'b1;
          b_req.rem     = 17'(b_rsp.rem[11:6]);
          b_req.dvd     = {b_rsp.rem[5:0], 10'd0};
          b_req.divisor = esc_pkg::SECS_PER_MIN;
          b_req.steps   = esc_pkg::MIN_STEPS;
          b_stage_nxt   = B_MIN;
        end
      end
      B_MIN: begin
        if (!b_rsp.busy) begin
          min_nxt     = b_rsp.quo[5:0];
          sec_nxt     = b_rsp.rem[5:0];
          b_stage_nxt = B_FIN;
        end
      end
      default: ;
    endcase

    case (state_r)
      S_IDLE: begin
        if (accept) begin
          mode_nxt     = in_tuser[0];
          year_in_nxt  = in_tdata[43:32];
          month_in_nxt = in_tdata[47:44];
          day_in_nxt   = in_tdata[52:48];
          hour_nxt     = in_tdata[57:53];
          min_nxt      = in_tdata[63:58];
          sec_nxt      = in_tdata[69:64];
          oor_nxt      = 1'b0;
          b_stage_nxt  = B_IDLE;
          if (!in_tuser[0]) begin
            state_nxt = S_CBASE;
          end else if (ts_in > esc_pkg::LAST_SECOND) begin
            yr_nxt    = esc_pkg::YEAR_SPAN;
            mon_nxt   = esc_pkg::LAST_MONTH_IDX;
            diy_nxt   = 9'd30;
            hour_nxt  = 5'd23;
            min_nxt   = 6'd59;
            sec_nxt   = 6'd59;
            oor_nxt   = 1'b1;
            state_nxt = S_DONE;
          end else begin
            // top 16 bits are below 86400, so the high quotient bits are zero
            a_req.load    = 1'b1;
            a_req.rem     = 17'(ts_in[31:16]);
            a_req.dvd     = ts_in[15:0];
            a_req.divisor = esc_pkg::SECS_PER_DAY;
            a_req.steps   = esc_pkg::DAY_STEPS;
            state_nxt     = S_DAYS;
          end
        end
      end
      S_DAYS: begin
        if (!a_rsp.busy) begin
          a_req.load    = 1'b1;
          a_req.rem     = 17'(a_rsp.quo[15:8]);
          a_req.dvd     = {a_rsp.quo[7:0], 8'd0};
          a_req.divisor = esc_pkg::DAYS_PER_YEAR;
          a_req.steps   = esc_pkg::YEAR_STEPS;
          b_req.load    = 1'b1;
          b_req.rem     = 17'(a_rsp.rem[16:5]);
          b_req.dvd     = {a_rsp.rem[4:0], 11'd0};
          b_req.divisor = esc_pkg::SECS_PER_HOUR;
          b_req.steps   = esc_pkg::HOUR_STEPS;
          b_stage_nxt   = B_HOUR;
          state_nxt     = S_YEAR;
        end
      end
      S_YEAR: begin
        if (!a_rsp.busy) begin
          if (r_est >= leap_days) begin
            yr_nxt  = q_est;
            diy_nxt = r_est - leap_days;
          end else begin
            yr_nxt  = q_est - YW'(1);
            diy_nxt = back_diy[8:0];
          end
          mon_nxt   = 4'd0;
          state_nxt = S_MONTH;
        end
      end
      S_MONTH: begin
        if (mon_r != esc_pkg::LAST_MONTH_IDX && diy_r >= 9'(mlen)) begin
          diy_nxt = diy_r - 9'(mlen);
          mon_nxt = mon_r + 4'd1;
        end else if (b_stage_r == B_FIN) begin
          state_nxt = S_DONE;
        end
      end
      S_CBASE: begin
        acc_nxt   = 32'(base_days);
        state_nxt = S_CDAYS;
      end
      S_CDAYS: begin
        acc_nxt   = acc_r + 32'(dbm) + 32'(dd);
        state_nxt = S_CHOUR;
      end
      S_CHOUR: begin
        acc_nxt   = (acc_r << 4) + (acc_r << 3) + 32'(hour_r);
        state_nxt = S_CMIN;
      end
      S_CMIN: begin
        acc_nxt   = (acc_r << 6) - (acc_r << 2) + 32'(min_r);
        state_nxt = S_CSEC;
      end
      S_CSEC: begin
        acc_nxt   = (acc_r << 6) - (acc_r << 2) + 32'(sec_r);
        state_nxt = S_DONE;
      end
      S_DONE: begin
        if (!out_tvalid_r || out_tready) begin
          if (mode_r) begin
            out_tdata_nxt = {2'd0, sec_r, min_r, hour_r, res_day, res_month, res_year, 32'd0};
          end else begin
            out_tdata_nxt = {40'd0, acc_r};
          end
          out_tuser_nxt  = res_oor;
          out_tvalid_nxt = 1'b1;
          state_nxt      = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      b_stage_r    <= B_IDLE;
      out_tvalid_r <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      b_stage_r    <= b_stage_nxt;
      out_tvalid_r <= out_tvalid_nxt;
    end
    mode_r      <= mode_nxt;
    year_in_r   <= year_in_nxt;
    month_in_r  <= month_in_nxt;
    day_in_r    <= day_in_nxt;
    hour_r      <= hour_nxt;
    min_r       <= min_nxt;
    sec_r       <= sec_nxt;
    acc_r       <= acc_nxt;
    yr_r        <= yr_nxt;
    mon_r       <= mon_nxt;
    diy_r       <= diy_nxt;
    oor_r       <= oor_nxt;
    out_tdata_r <= out_tdata_nxt;
    out_tuser_r <= out_tuser_nxt;
  end

  assign out_tvalid   = out_tvalid_r;
  assign out_tdata    = out_tdata_r;
  assign out_tuser[0] = out_tuser_r;

endmodule

>>> tb/sv/testbench.sv
// self-checking testbench for the epoch seconds calendar converter
module testbench;

  localparam logic REQ_CAL_TO_SECS = 1'b0;
  localparam logic REQ_SECS_TO_CAL = 1'b1;

  localparam logic [31:0] LAST_SECOND   = 32'd4102444799;
  localparam int          RANDOM_ITEMS  = 950;
  localparam int          HOLD_AT       = 150;
  localparam int          HOLD_CYCLES   = 400;
  localparam int          STALL_LIMIT   = 3000;
  localparam int          DRAIN_CYCLES  = 100;

  typedef struct packed {
    logic        req_type;
    logic [31:0] epoch_seconds;
    logic [11:0] year;
    logic [3:0]  month;
    logic [4:0]  day;
    logic [4:0]  hour;
    logic [5:0]  minute;
    logic [5:0]  second;
  } conversion_req_t;

  typedef struct packed {
    logic [31:0] seconds;
    logic [11:0] year;
    logic [3:0]  month;
    logic [4:0]  day;
    logic [4:0]  hour;
    logic [5:0]  minute;
    logic [5:0]  second;
    logic        over;
  } calendar_result_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_tvalid = 1'b0;
  logic in_tready;
  logic [esc_pkg::IN_TDATA_W-1:0] in_tdata = '0;
  logic [0:0] in_tuser = '0;
  logic out_tvalid;
  logic out_tready = 1'b0;
  logic [esc_pkg::OUT_TDATA_W-1:0] out_tdata;
  logic [0:0] out_tuser;

  conversion_req_t  pending_requests[$];
  calendar_result_t expected_results[$];
  conversion_req_t  offered_req;
  calendar_result_t seen_result;
  calendar_result_t oldest_result;

  int n_accepted = 0;
  int total_items = 0;
  int results_seen = 0;
  int hold_left = 0;
  bit hold_done = 1'b0;
  int stall_cycles = 0;
  int mismatch_count = 0;
  int sender_idle_pct;
  int receiver_idle_pct;

  epoch_seconds_calendar_converter DUT (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // first third: sender 30, receiver 52; second third swapped; last third no idling
  assign sender_idle_pct = (n_accepted * 3 < total_items) ? 30 :
                           (n_accepted * 3 < 2 * total_items) ? 52 : 0;
  assign receiver_idle_pct = (n_accepted * 3 < total_items) ? 52 :
                             (n_accepted * 3 < 2 * total_items) ? 30 : 0;

  function automatic int unsigned month_length(int unsigned idx, bit leap);
    case (idx)
      1: return leap ? 29 : 28;
      3, 5, 8, 10: return 30;
      default: return 31;
    endcase
  endfunction

  function automatic calendar_result_t predict_conversion(conversion_req_t r);
    calendar_result_t res;
    int unsigned yr, mon, dy, yoff, day_count, tod, m;
    longint unsigned total;
    bit leap;
    res = '0;
    if (r.req_type == REQ_CAL_TO_SECS) begin
      yr = r.year;
      if (yr < 1970) yr = 1970;
      if (yr > 2099) yr = 2099;
      mon = r.month;
      if (mon < 1) mon = 1;
      if (mon > 12) mon = 12;
      dy = r.day;
      if (dy == 0) dy = 1;
      yoff = yr - 1970;
      leap = (yr % 4) == 0;
      day_count = yoff * 365 + (yr - 1969) / 4;
      for (m = 0; m + 1 < mon; m++) begin
        day_count += month_length(m, leap);
      end
      day_count += dy - 1;
      // day (but for zero), hour, minute and second are not range checked, they just add on
      total = 64'(day_count) * 86400 + 64'(r.hour) * 3600 + 64'(r.minute) * 60
              + 64'(r.second);
      res.seconds = total[31:0];
      res.over = total > 64'(LAST_SECOND);
    end else if (r.epoch_seconds > LAST_SECOND) begin
      res.year = 12'd2099;
      res.month = 4'd12;
      res.day = 5'd31;
      res.hour = 5'd23;
      res.minute = 6'd59;
      res.second = 6'd59;
      res.over = 1'b1;
    end else begin
      day_count = r.epoch_seconds / 86400;
      tod = r.epoch_seconds % 86400;
      // days / 365 overshoots near year end once leap days pile up
      yoff = day_count / 365;
      while (yoff > 0 && day_count < yoff * 365 + (yoff + 1) / 4) begin
        yoff--;
      end
      day_count -= yoff * 365 + (yoff + 1) / 4;
      leap = ((yoff + 2) % 4) == 0;
      m = 0;
      while (m < 11 && day_count >= month_length(m, leap)) begin
        day_count -= month_length(m, leap);
        m++;
      end
      res.year = 12'(yoff + 1970);
      res.month = 4'(m + 1);
      res.day = 5'(day_count + 1);
      res.hour = 5'(tod / 3600);
      res.minute = 6'((tod % 3600) / 60);
      res.second = 6'(tod % 60);
    end
    return res;
  endfunction

  function automatic conversion_req_t cal_request(int unsigned y, int unsigned mo,
                                                   int unsigned d, int unsigned h,
                                                   int unsigned mi, int unsigned s);
    conversion_req_t r;
    r = '0;
    r.req_type = REQ_CAL_TO_SECS;
    r.year = 12'(y);
    r.month = 4'(mo);
    r.day = 5'(d);
    r.hour = 5'(h);
    r.minute = 6'(mi);
    r.second = 6'(s);
    return r;
  endfunction

  function automatic conversion_req_t secs_request(logic [31:0] ts);
    conversion_req_t r;
    r = '0;
    r.req_type = REQ_SECS_TO_CAL;
    r.epoch_seconds = ts;
    return r;
  endfunction

  function automatic logic [31:0] seconds_at(int unsigned y, int unsigned mo,
                                             int unsigned d, int unsigned h,
                                             int unsigned mi, int unsigned s);
    calendar_result_t c;
    c = predict_conversion(cal_request(y, mo, d, h, mi, s));
    return c.seconds;
  endfunction

  function automatic conversion_req_t random_request();
    conversion_req_t r;
    int unsigned pick, mo;
    longint signed ts;
    // unused fields carry noise
    r.req_type = 1'($urandom_range(1));
    r.epoch_seconds = $urandom;
    r.year = 12'($urandom);
    r.month = 4'($urandom);
    r.day = 5'($urandom);
    r.hour = 5'($urandom);
    r.minute = 6'($urandom);
    r.second = 6'($urandom);
    pick = $urandom_range(99);
    if (r.req_type == REQ_CAL_TO_SECS) begin
      if (pick < 80) begin
        r.year = 12'($urandom_range(2099, 1970));
        r.month = 4'($urandom_range(12, 1));
        r.day = 5'($urandom_range(31, 1));
        r.hour = 5'($urandom_range(23));
        r.minute = 6'($urandom_range(59));
        r.second = 6'($urandom_range(59));
      end
    end else if (pick < 40) begin
      r.epoch_seconds = $urandom_range(LAST_SECOND);
    end else if (pick < 75) begin
      // around year, february and month ends where the searches turn over
      case ($urandom_range(3))
        0: mo = 1;
        1: mo = 3;
        2: mo = 12;
        default: mo = $urandom_range(12, 1);
      endcase
      ts = longint'(seconds_at($urandom_range(2099, 1970), mo, 1, 0, 0, 0))
           + longint'($urandom_range(4 * 86400)) - 2 * 86400;
      if (ts < 0) ts = 0;
      if (ts > longint'(LAST_SECOND)) ts = longint'(LAST_SECOND);
      r.epoch_seconds = 32'(ts);
    end else if (pick < 85) begin
      r.epoch_seconds = LAST_SECOND - 32'd1000 + 32'($urandom_range(2000));
    end
    return r;
  endfunction

  task automatic check_field(string name, longint unsigned want, longint unsigned got);
    if (want != got) begin
      $error("%s mismatch: expected %0d, got %0d", name, want, got);
      mismatch_count++;
    end
  endtask

  // request driver
  always @(posedge clk) begin
    if (!rst_n) begin
      in_tvalid <= 1'b0;
    end else begin
      if (in_tvalid && in_tready) begin
        expected_results.push_back(predict_conversion(offered_req));
        n_accepted <= n_accepted + 1;
      end
      if (!in_tvalid || in_tready) begin
        if (pending_requests.size() != 0 && $urandom_range(99) >= sender_idle_pct) begin
          offered_req = pending_requests.pop_front();
          in_tvalid <= 1'b1;
          in_tdata <= {2'b00, offered_req.second, offered_req.minute, offered_req.hour,
                       offered_req.day, offered_req.month, offered_req.year,
                       offered_req.epoch_seconds};
          in_tuser <= offered_req.req_type;
        end else begin
          in_tvalid <= 1'b0;
        end
      end
    end
  end

  // result monitor and receiver
  always @(posedge clk) begin
    if (!rst_n) begin
      out_tready <= 1'b0;
    end else begin
      if (out_tvalid && out_tready) begin
        seen_result.seconds = out_tdata[31:0];
        seen_result.year = out_tdata[43:32];
        seen_result.month = out_tdata[47:44];
        seen_result.day = out_tdata[52:48];
        seen_result.hour = out_tdata[57:53];
        seen_result.minute = out_tdata[63:58];
        seen_result.second = out_tdata[69:64];
        seen_result.over = out_tuser[0];
        results_seen++;
        if (expected_results.size() == 0) begin
          $error("result with no request outstanding: tdata %h tuser %b",
                 out_tdata, out_tuser);
          mismatch_count++;
        end else begin
          oldest_result = expected_results.pop_front();
          check_field("out_seconds", oldest_result.seconds, seen_result.seconds);
          check_field("out_year", oldest_result.year, seen_result.year);
          check_field("out_month", oldest_result.month, seen_result.month);
          check_field("out_day", oldest_result.day, seen_result.day);
          check_field("out_hour", oldest_result.hour, seen_result.hour);
          check_field("out_minute", oldest_result.minute, seen_result.minute);
          check_field("out_second", oldest_result.second, seen_result.second);
          check_field("out_of_range", oldest_result.over, seen_result.over);
        end
      end
      // one long hold-off so the block backs up into its input
      if (hold_left != 0) begin
        hold_left <= hold_left - 1;
        out_tready <= 1'b0;
      end else if (!hold_done && results_seen >= HOLD_AT) begin
        hold_done <= 1'b1;
        hold_left <= HOLD_CYCLES;
        out_tready <= 1'b0;
      end else begin
        out_tready <= ($urandom_range(99) >= receiver_idle_pct);
      end
    end
  end

  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_tvalid && in_tready) || (out_tvalid && out_tready)) begin
        stall_cycles <= 0;
      end else begin
        stall_cycles <= stall_cycles + 1;
      end
      if (stall_cycles >= STALL_LIMIT) begin
        $display("TB_ERROR");
        $finish;
      end
    end
  end

  initial begin
    int i;
    // calendar to seconds: range ends, clamped fields, overflowing day and time
    pending_requests.push_back(cal_request(1970, 1, 1, 0, 0, 0));
    pending_requests.push_back(cal_request(2099, 12, 31, 23, 59, 59));
    pending_requests.push_back(cal_request(2099, 12, 31, 31, 63, 63));
    pending_requests.push_back(cal_request(0, 0, 0, 0, 0, 0));
    pending_requests.push_back(cal_request(4095, 15, 31, 31, 63, 63));
    pending_requests.push_back(cal_request(1969, 13, 1, 12, 30, 30));
    pending_requests.push_back(cal_request(2100, 2, 29, 0, 0, 1));
    pending_requests.push_back(cal_request(2000, 2, 31, 12, 0, 0));
    pending_requests.push_back(cal_request(2024, 2, 29, 6, 7, 8));
    pending_requests.push_back(cal_request(1972, 12, 31, 23, 59, 59));
    pending_requests.push_back(cal_request(2023, 3, 1, 0, 0, 0));
    // seconds to calendar: ends, overflow, year estimate too high
    pending_requests.push_back(secs_request(32'd0));
    pending_requests.push_back(secs_request(LAST_SECOND));
    pending_requests.push_back(secs_request(LAST_SECOND + 32'd1));
    pending_requests.push_back(secs_request(32'hFFFF_FFFF));
    pending_requests.push_back(secs_request(32'h7FFF_FFFF));
    pending_requests.push_back(secs_request(seconds_at(1972, 12, 31, 0, 0, 0)));
    pending_requests.push_back(secs_request(seconds_at(1971, 12, 31, 23, 59, 59)));
    pending_requests.push_back(secs_request(seconds_at(2096, 12, 31, 23, 59, 59)));
    pending_requests.push_back(secs_request(seconds_at(2097, 1, 1, 0, 0, 0)));
    pending_requests.push_back(secs_request(seconds_at(2000, 2, 29, 12, 34, 56)));
    pending_requests.push_back(secs_request(seconds_at(2001, 3, 1, 0, 0, 0)));
    pending_requests.push_back(secs_request(seconds_at(2099, 12, 31, 0, 0, 0)));
    for (i = 0; i < RANDOM_ITEMS; i++) begin
      pending_requests.push_back(random_request());
    end
    total_items = pending_requests.size();
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    while (pending_requests.size() != 0 || in_tvalid || expected_results.size() != 0) begin
      @(posedge clk);
    end
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
